// ----- hw/rtl/dact_pkg.sv -----
// Shared types and constants for the depth-adaptive confidence threshold block.
package dact_pkg;

    localparam int DEPTH_W = 16;
    localparam int CONF_W  = 16;
    localparam int THR_W   = 16;
    localparam int CMD_W   = 2;
    localparam int CFG_IDX_W = 8;

    // tdata widths, rounded up to whole bytes
    localparam int S_TDATA_W = DEPTH_W + CONF_W;
    localparam int M_TDATA_W = 8;

    // signed difference of two unsigned Q0.16 values, and its product with a span
    localparam int DIFF_W = CONF_W + 1;
    localparam int PROD_W = DIFF_W + DEPTH_W + 1;

    typedef logic [CMD_W-1:0]     t_cmd;
    typedef logic [DEPTH_W-1:0]   t_depth;
    typedef logic [CONF_W-1:0]    t_conf;
    typedef logic [THR_W-1:0]     t_thr;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cmd CMD_START    = 2'd0;
    localparam t_cmd CMD_ACCUM    = 2'd1;
    localparam t_cmd CMD_CLASSIFY = 2'd2;

    localparam t_cfg_idx REG_NEAR = 8'd0;
    localparam t_cfg_idx REG_FAR  = 8'd1;

    localparam t_thr   THR_RESET       = 16'd32768;
    localparam t_depth DEPTH_MIN_RESET = 16'hFFFF;
    localparam t_depth DEPTH_MAX_RESET = 16'h0000;

endpackage

// ----- hw/rtl/depth_adaptive_confidence_threshold.sv -----
// Top level of the depth-adaptive confidence threshold block.
// Each frame is streamed twice. A start transaction (tuser = 0) clears the depth statistics;
// accumulate transactions (tuser = 1) track the minimum and maximum non-zero depth; classify
// transactions (tuser = 2) yield one result each: foreground is set when the confidence reaches
// a threshold interpolated linearly from near_threshold at the minimum depth to far_threshold at
// the maximum depth (depth clamped into that span). The test is exact, by cross-multiplication:
// (conf - near) * span >= (far - near) * offset. Frames without a valid depth span, and pixels
// with depth 0, use near_threshold; used_fallback marks the former. Tuser = 3 is ignored.
// Rate: one input transaction per cycle while the pipeline is not backed up. Start and
// accumulate finish at acceptance. A classify goes through three pipeline registers (operand
// prep, two 17x17 multipliers, compare); the first loads at the accepting edge and the result
// leaves from the third. Each stage stalls only when the stage after it is full and
// stalled, so the input keeps taking transactions while a result waits at the output until all
// three stages hold results. Statistics are read at acceptance, so later accumulate
// transactions never affect a classify already in flight. Threshold registers are written over
// the configuration channel, which is always ready; write them only while the block is idle.
module depth_adaptive_confidence_threshold (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // input stream
    input  logic                       i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    input  logic [dact_pkg::S_TDATA_W-1:0] i_s_axis_tdata,  // [15:0] depth_mm, [31:16] confidence
    input  logic [dact_pkg::CMD_W-1:0] i_s_axis_tuser,      // [1:0] command
    // result stream
    output logic                       o_m_axis_tvalid,
    input  logic                       i_m_axis_tready,
    output logic [dact_pkg::M_TDATA_W-1:0] o_m_axis_tdata,  // [0] foreground, [1] used_fallback
    // configuration write channel
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [dact_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [dact_pkg::THR_W-1:0] i_cfg_data
);
    import dact_pkg::*;

    // threshold registers
    t_thr r_near;
    t_thr r_far;

    // frame statistics
    t_depth r_dmin, n_dmin;
    t_depth r_dmax, n_dmax;
    logic   r_seen, n_seen;

    // pipeline stage 1: prepared operands
    logic              r1_v;
    logic              r1_fb;
    t_depth            r1_span;
    t_depth            r1_off;
    logic [DIFF_W-1:0] r1_dcn;
    logic [DIFF_W-1:0] r1_dfn;

    // pipeline stage 2: products
    logic                     r2_v;
    logic                     r2_fb;
    logic signed [PROD_W-1:0] r2_p_conf;
    logic signed [PROD_W-1:0] r2_p_thr;

    // stage 3: result register
    logic r3_v;
    logic r3_fg;
    logic r3_fb;

    logic en1, en2, en3;
    logic s_accept;

    t_cmd   in_cmd;
    t_depth in_depth;
    t_conf  in_conf;

    // classify operand prep
    logic   c_fb;
    logic   c_plain;
    t_depth c_dclamp;
    t_depth c_span;
    t_depth c_off;
    logic [DIFF_W-1:0] c_dcn;
    logic [DIFF_W-1:0] c_dfn;

    logic signed [PROD_W-1:0] c_p_conf;
    logic signed [PROD_W-1:0] c_p_thr;

    assign in_cmd   = i_s_axis_tuser;
    assign in_depth = i_s_axis_tdata[DEPTH_W-1:0];
    assign in_conf  = i_s_axis_tdata[DEPTH_W +: CONF_W];

    // stall chain: a stage moves when it is empty or the next one moves
    assign en3 = !r3_v || i_m_axis_tready;
    assign en2 = !r2_v || en3;
    assign en1 = !r1_v || en2;

    assign o_s_axis_tready = en1;
    assign s_accept        = i_s_axis_tvalid && en1;

    assign o_cfg_ready = 1'b1;

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_near <= THR_RESET;
            r_far  <= THR_RESET;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == REG_NEAR) begin
                r_near <= i_cfg_data;
            end
            if (i_cfg_index == REG_FAR) begin
                r_far <= i_cfg_data;
            end
        end
    end

    // ---------------- statistics ----------------
    always_comb begin
        n_dmin = r_dmin;
        n_dmax = r_dmax;
        n_seen = r_seen;
        if (s_accept) begin
            if (in_cmd == CMD_START) begin
                n_dmin = DEPTH_MIN_RESET;
                n_dmax = DEPTH_MAX_RESET;
                n_seen = 1'b0;
            end else if (in_cmd == CMD_ACCUM && in_depth != '0) begin
                if (in_depth < r_dmin) begin
                    n_dmin = in_depth;
                end
                if (in_depth > r_dmax) begin
                    n_dmax = in_depth;
                end
                n_seen = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dmin <= DEPTH_MIN_RESET;
            r_dmax <= DEPTH_MAX_RESET;
            r_seen <= 1'b0;
        end else begin
            r_dmin <= n_dmin;
            r_dmax <= n_dmax;
            r_seen <= n_seen;
        end
    end

    // ---------------- stage 1: operand prep ----------------
    // Fallback frames and invalid pixels reduce to span = 1, offset = 0, which turns the
    // cross-multiplied test into conf >= near.
    always_comb begin
        c_fb    = !r_seen || (r_dmax <= r_dmin);
        c_plain = c_fb || (in_depth == '0);
        priority if (in_depth < r_dmin) begin
            c_dclamp = r_dmin;
        end else if (in_depth > r_dmax) begin
            c_dclamp = r_dmax;
        end else begin
            c_dclamp = in_depth;
        end
        if (c_plain) begin
            c_span = t_depth'(1);
            c_off  = '0;
        end else begin
            c_span = r_dmax - r_dmin;
            c_off  = c_dclamp - r_dmin;
        end
        c_dcn = {1'b0, in_conf} - {1'b0, r_near};
        c_dfn = {1'b0, r_far} - {1'b0, r_near};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (en1) begin
            r1_v <= s_accept && (in_cmd == CMD_CLASSIFY);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_fb   <= c_fb;
            r1_span <= c_span;
            r1_off  <= c_off;
            r1_dcn  <= c_dcn;
            r1_dfn  <= c_dfn;
        end
    end

    // ---------------- stage 2: products ----------------
    assign c_p_conf = PROD_W'($signed(r1_dcn) * $signed({1'b0, r1_span}));
    assign c_p_thr  = PROD_W'($signed(r1_dfn) * $signed({1'b0, r1_off}));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (en2) begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r2_fb     <= r1_fb;
            r2_p_conf <= c_p_conf;
            r2_p_thr  <= c_p_thr;
        end
    end

    // ---------------- stage 3: compare, result register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (en3) begin
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r3_fg <= (r2_p_conf >= r2_p_thr);
            r3_fb <= r2_fb;
        end
    end

    assign o_m_axis_tvalid = r3_v;
    assign o_m_axis_tdata  = {{(M_TDATA_W-2){1'b0}}, r3_fb, r3_fg};

endmodule

// ----- hw/rtl/dact_checker.sv -----
// Port-level checker for the depth-adaptive confidence threshold block, with its bind.
module dact_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_s_axis_tvalid,
    input logic                           o_s_axis_tready,
    input logic                           o_m_axis_tvalid,
    input logic                           i_m_axis_tready,
    input logic [dact_pkg::M_TDATA_W-1:0] o_m_axis_tdata
);
    // pipeline empties on reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid right after reset");

    // input backpressure only when the output itself is backed up
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && !o_s_axis_tready) |-> (o_m_axis_tvalid && !i_m_axis_tready))
        else $error("input stalled while output free");

    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=> o_m_axis_tvalid)
        else $error("result dropped while stalled");

    a_data_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=> $stable(o_m_axis_tdata))
        else $error("result changed while stalled");

endmodule

bind depth_adaptive_confidence_threshold dact_checker u_dact_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

// ----- tb/tb.sv -----
// Self-checking testbench for the depth-adaptive confidence threshold block.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dact_pkg::*;

    // tuser value with no meaning; the block must drop it silently
    localparam t_cmd     CMD_UNUSED = 2'd3;
    // first register index past the implemented ones; writes there are dropped
    localparam t_cfg_idx REG_SPARE  = 8'd2;
    // drain time before a register write: three pipeline stages plus margin
    localparam int       SETTLE_CYCLES = 8;

    // expected result of one classify transaction
    typedef struct packed {
        logic foreground;
        logic used_fallback;
    } t_pixel_verdict;

    // ------------------------------------------------------------------
    // Scoreboard: mirrors the frame statistics and thresholds, predicts one
    // verdict per classify transaction and checks results in order.
    // ------------------------------------------------------------------
    class verdict_board;
        t_thr           near_thr;
        t_thr           far_thr;
        t_depth         depth_lo;
        t_depth         depth_hi;
        logic           any_valid;
        t_pixel_verdict verdicts[$];
        int unsigned    errors;
        int unsigned    n_checked;

        function new();
            near_thr  = THR_RESET;
            far_thr   = THR_RESET;
            depth_lo  = DEPTH_MIN_RESET;
            depth_hi  = DEPTH_MAX_RESET;
            any_valid = 1'b0;
            errors    = 0;
            n_checked = 0;
        endfunction

        function int unsigned pending();
            return verdicts.size();
        endfunction

        function void write_reg(t_cfg_idx idx, t_thr value);
            if (idx == REG_NEAR) begin
                near_thr = value;
            end else if (idx == REG_FAR) begin
                far_thr = value;
            end
        endfunction

        function void note_pixel(t_cmd cmd, t_depth depth, t_conf conf);
            t_pixel_verdict v;
            t_depth         d;
            logic [47:0]    span;
            logic [47:0]    off;
            logic [47:0]    lhs;
            logic [47:0]    rhs;
            case (cmd)
                CMD_START: begin
                    depth_lo  = DEPTH_MIN_RESET;
                    depth_hi  = DEPTH_MAX_RESET;
                    any_valid = 1'b0;
                end
                CMD_ACCUM: begin
                    // zero depth is an invalid pixel and leaves the stats alone
                    if (depth != '0) begin
                        if (depth < depth_lo) depth_lo = depth;
                        if (depth > depth_hi) depth_hi = depth;
                        any_valid = 1'b1;
                    end
                end
                CMD_CLASSIFY: begin
                    if (!any_valid || depth_hi <= depth_lo) begin
                        // no usable span in this frame
                        v.used_fallback = 1'b1;
                        v.foreground    = (conf >= near_thr);
                    end else if (depth == '0) begin
                        // invalid pixel in an adaptive frame
                        v.used_fallback = 1'b0;
                        v.foreground    = (conf >= near_thr);
                    end else begin
                        d = depth;
                        if (d < depth_lo) d = depth_lo;
                        if (d > depth_hi) d = depth_hi;
                        span = 48'(depth_hi - depth_lo);
                        off  = 48'(d - depth_lo);
                        // conf >= (near*(span-off) + far*off) / span, no division
                        lhs  = 48'(conf) * span;
                        rhs  = 48'(near_thr) * (span - off) + 48'(far_thr) * off;
                        v.used_fallback = 1'b0;
                        v.foreground    = (lhs >= rhs);
                    end
                    verdicts.insert(verdicts.size(), v);
                end
                default: ;
            endcase
        endfunction

        task report_mismatch(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_verdict(logic [M_TDATA_W-1:0] tdata);
            t_pixel_verdict want;
            if (verdicts.size() == 0) begin
                report_mismatch($sformatf("result 0x%02h with nothing expected", tdata));
                return;
            end
            want = verdicts.pop_front();
            if (tdata[0] !== want.foreground) begin
                report_mismatch($sformatf("result %0d foreground %b, want %b",
                                          n_checked, tdata[0], want.foreground));
            end
            if (tdata[1] !== want.used_fallback) begin
                report_mismatch($sformatf("result %0d used_fallback %b, want %b",
                                          n_checked, tdata[1], want.used_fallback));
            end
            n_checked++;
        endtask
    endclass

    // ------------------------------------------------------------------
    // Clock, DUT signals and instance
    // ------------------------------------------------------------------
    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata;
    t_cmd                   s_tuser;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   cfg_valid;
    logic                   cfg_ready;
    t_cfg_idx               cfg_index;
    t_thr                   cfg_data;

    verdict_board           sb;
    // threshold values the stimulus aims confidence values at
    t_thr                   cur_near = THR_RESET;
    t_thr                   cur_far  = THR_RESET;
    // when set, neither side inserts idle cycles
    logic                   burst_mode = 1'b0;

    always #1 i_clk = ~i_clk;

    depth_adaptive_confidence_threshold dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),     // [15:0] depth_mm, [31:16] confidence
        .i_s_axis_tuser  (s_tuser),     // [1:0] command
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),     // [0] foreground, [1] used_fallback
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    // ------------------------------------------------------------------
    // Monitor: everything is sampled at the rising edge, before the DUT's
    // registers move. The output is checked before the input is noted so a
    // classify never matches a result in the same cycle it was accepted.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_tvalid && m_tready) sb.check_verdict(m_tdata);
            if (s_tvalid && s_tready) begin
                sb.note_pixel(s_tuser, s_tdata[DEPTH_W-1:0],
                              s_tdata[DEPTH_W +: CONF_W]);
            end
            if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
        end
    end

    // Result sink: a fresh random stall before every result transaction.
    always begin : result_sink
        int unsigned stall;
        @(negedge i_clk);
        stall = burst_mode ? 0 : $urandom_range(0, 5);
        if (stall != 0) begin
            m_tready = 1'b0;
            repeat (stall) @(negedge i_clk);
        end
        m_tready = 1'b1;
        do @(posedge i_clk); while (!(m_tvalid && m_tready));
    end

    // ------------------------------------------------------------------
    // Drivers. Each is entered at a falling edge and returns at one.
    // tvalid stays high across back-to-back transactions.
    // ------------------------------------------------------------------
    task automatic send_item(t_cmd cmd, t_depth depth, t_conf conf);
        int unsigned gap;
        gap = burst_mode ? 0 : $urandom_range(0, 5);
        if (gap != 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = cmd;
        s_tdata  = {conf, depth};
        do @(posedge i_clk); while (!s_tready);
        @(negedge i_clk);
    endtask

    // leaves cfg_valid high; the caller lowers it after the last write
    task automatic write_reg(t_cfg_idx idx, t_thr value);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        do @(posedge i_clk); while (!cfg_ready);
        @(negedge i_clk);
    endtask

    // wait until every classify has come back, then let the pipe settle
    task automatic drain();
        s_tvalid = 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // writes only on an idle block, draining it first; a write to a spare index is slipped in
    task automatic program_thresholds(t_thr near_val, t_thr far_val);
        drain();
        write_reg(REG_NEAR, near_val);
        write_reg(t_cfg_idx'($urandom_range(REG_SPARE, {CFG_IDX_W{1'b1}})), t_thr'($urandom));
        write_reg(REG_FAR, far_val);
        cfg_valid = 1'b0;
        cur_near  = near_val;
        cur_far   = far_val;
    endtask

    // Random frames: mostly start / accumulate pass / classify pass, with
    // missing starts, stray accumulates in the classify pass and unused
    // commands mixed in. Only transactions the block acts on count.
    task automatic random_phase(int unsigned budget);
        int unsigned sent;
        int unsigned n_acc;
        int unsigned n_cls;
        int unsigned k;
        int unsigned sel;
        int          lo;
        int          hi;
        int          d;
        t_cmd        cmd;
        t_conf       c;
        sent = 0;
        while (sent < budget) begin
            if ($urandom_range(0, 9) != 0) begin
                send_item(CMD_START, t_depth'($urandom), t_conf'($urandom));
                sent++;
            end
            lo = $urandom_range(1, 65535);
            case ($urandom_range(0, 3))
                0: hi = lo;                                 // zero span
                1: hi = lo + $urandom_range(1, 15);
                2: hi = lo + $urandom_range(16, 2000);
                default: begin                              // near full range
                    lo = $urandom_range(1, 64);
                    hi = $urandom_range(65000, 65535);
                end
            endcase
            if (hi > 65535) hi = 65535;
            n_acc = $urandom_range(0, 8);
            for (k = 0; k < n_acc; k++) begin
                case ($urandom_range(0, 7))
                    0: d = 0;
                    1: d = lo;
                    2: d = hi;
                    default: d = $urandom_range(lo, hi);
                endcase
                send_item(CMD_ACCUM, t_depth'(d), t_conf'($urandom));
                sent++;
            end
            n_cls = $urandom_range(1, 10);
            for (k = 0; k < n_cls; k++) begin
                sel = $urandom_range(0, 15);
                cmd = (sel == 0) ? CMD_UNUSED : (sel == 1) ? CMD_ACCUM : CMD_CLASSIFY;
                case ($urandom_range(0, 7))
                    0: d = 0;
                    1: d = $urandom_range(0, 65535);        // anywhere, exercises clamping
                    2: d = lo;
                    3: d = hi;
                    default: d = $urandom_range(lo, hi);
                endcase
                case ($urandom_range(0, 5))
                    0: c = cur_near;
                    1: c = cur_far;
                    2: c = cur_near - 16'd1;
                    3: c = cur_far + 16'd1;
                    default: c = t_conf'($urandom);
                endcase
                send_item(cmd, t_depth'(d), c);
                if (cmd != CMD_UNUSED) sent++;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        sb        = new();
        i_rst_n   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = CMD_START;
        cfg_valid = 1'b0;
        cfg_index = REG_NEAR;
        cfg_data  = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset thresholds, no frame seen yet: fallback at the boundary
        send_item(CMD_CLASSIFY, 16'd1234, 16'h8000);
        send_item(CMD_CLASSIFY, 16'd1234, 16'h7FFF);

        program_thresholds(16'h1000, 16'hF000);
        send_item(CMD_UNUSED,   16'd700,   16'hFFFF);    // must not touch the stats
        send_item(CMD_START,    16'hFFFF,  16'hFFFF);
        send_item(CMD_ACCUM,    16'd0,     16'd0);       // invalid depth, ignored
        send_item(CMD_ACCUM,    16'd500,   16'd0);
        send_item(CMD_CLASSIFY, 16'd500,   16'h1000);    // single depth: zero span
        send_item(CMD_ACCUM,    16'd1,     16'd0);
        send_item(CMD_ACCUM,    16'hFFFF,  16'd0);
        send_item(CMD_ACCUM,    16'd3000,  16'd0);
        send_item(CMD_CLASSIFY, 16'd0,     16'h0FFF);    // invalid pixel, near threshold
        send_item(CMD_CLASSIFY, 16'd0,     16'h1000);
        send_item(CMD_CLASSIFY, 16'd1,     16'h1000);    // exactly at near end
        send_item(CMD_CLASSIFY, 16'hFFFF,  16'hEFFF);    // just under far end
        send_item(CMD_CLASSIFY, 16'hFFFF,  16'hF000);
        send_item(CMD_CLASSIFY, 16'd32768, 16'h8000);    // midpoint, exact tie
        send_item(CMD_CLASSIFY, 16'd32768, 16'h7FFF);
        send_item(CMD_CLASSIFY, 16'd1,     16'h0000);
        send_item(CMD_START,    16'd0,     16'd0);
        send_item(CMD_ACCUM,    16'd4000,  16'd0);
        send_item(CMD_ACCUM,    16'd2000,  16'd0);
        send_item(CMD_CLASSIFY, 16'd1,     16'h1000);    // below span, clamped to min
        send_item(CMD_CLASSIFY, 16'hFFFF,  16'hEFFF);    // above span, clamped to max
        send_item(CMD_START,    16'd0,     16'd0);
        send_item(CMD_CLASSIFY, 16'd2500,  16'hFFFF);    // empty frame

        // random phases, one per threshold setting; the third runs without gaps
        program_thresholds(16'h0000, 16'hFFFF);
        random_phase(150);
        program_thresholds(16'hFFFF, 16'h0000);
        random_phase(150);
        program_thresholds(16'd12345, 16'd12345);
        burst_mode = 1'b1;
        random_phase(150);
        program_thresholds(t_thr'($urandom), t_thr'($urandom));
        burst_mode = 1'b0;
        random_phase(150);
        program_thresholds(t_thr'($urandom), t_thr'($urandom));
        random_phase(150);

        drain();
        if (sb.errors == 0) begin
            $display("[depth_adaptive_confidence_threshold] OK");
        end else begin
            $display("[depth_adaptive_confidence_threshold] ERROR");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #200_000;
        $display("[depth_adaptive_confidence_threshold] ERROR");
        $finish;
    end

endmodule
